// File: rtl/deq_pkg.sv
`timescale 1ns / 1ps
// shared constants, request and status codes, and types for the deque core
// no dependencies

package deq_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // request codes
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_LIST       = 3'd4;

  // status codes
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_OVERFLOW   = 2'd1;
  localparam logic [1:0] STAT_UNDERFLOW  = 2'd2;
  localparam logic [1:0] STAT_EMPTY_LIST = 2'd3;

  typedef struct packed {
    logic [2:0]            op;
    logic [DATA_WIDTH-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             listing;
    logic             cmd_take;
  } back_stat_t;

endpackage

// File: rtl/deq_front.sv
`timescale 1ns / 1ps
// request intake: drops unknown request codes and queues the rest for the back end
// depends on deq_pkg

module deq_front import deq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic [2:0]            req_type,
  input  logic [DATA_WIDTH-1:0] value_in,
  output logic                  cmd_valid,
  output cmd_t                  cmd,
  input  logic                  cmd_take
);

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  cmd_t               fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   fill;
  logic               known;
  logic               push;
  logic               pop;

  assign req_stall = (fill == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign known     = (req_type == REQ_PUSH_FRONT) || (req_type == REQ_PUSH_BACK) ||
                     (req_type == REQ_POP_FRONT) || (req_type == REQ_POP_BACK) ||
                     (req_type == REQ_LIST);
  // unknown codes are accepted and dropped without a response
  assign push      = req_valid && !req_stall && known;
  assign pop       = cmd_take && cmd_valid;
  assign cmd_valid = (fill != '0);
  assign cmd       = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= '{op: req_type, value: value_in};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: rtl/deq_back.sv
`timescale 1ns / 1ps
// execution side: ring buffer store, front pointer, element count, list walker
// and the response register; depends on deq_pkg

module deq_back import deq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  input  cmd_t                  cmd,
  output logic                  cmd_take,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic [1:0]            status,
  output logic [DATA_WIDTH-1:0] value_out,
  output logic                  last,
  output back_stat_t            stat
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata;
  logic [ADDR_W-1:0]     rd_addr;

  logic [1:0]        state;
  logic [ADDR_W-1:0] front;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  idx;

  logic              out_free;
  logic              full;
  logic              empty;
  logic              list_last;
  logic [ADDR_W-1:0] front_dec;
  logic [ADDR_W-1:0] back_slot;

  // a + b modulo DEPTH, with a below DEPTH and b at most DEPTH
  function automatic logic [ADDR_W-1:0] wrap_add(logic [ADDR_W-1:0] a, logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
    if (s >= (CNT_W + 1)'(DEPTH)) begin
      s = s - (CNT_W + 1)'(DEPTH);
    end
    return s[ADDR_W-1:0];
  endfunction

  assign out_free  = !rsp_valid || !rsp_stall;
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign front_dec = (front == '0) ? ADDR_W'(DEPTH - 1) : front - 1'b1;
  assign back_slot = wrap_add(front, count);
  assign rd_addr   = wrap_add(front, idx);
  assign list_last = ((idx + 1'b1) == count);
  assign cmd_take  = (state == S_IDLE) && cmd_valid && out_free;

  assign stat = '{count: count, listing: (state != S_IDLE), cmd_take: cmd_take};

  // store write on push, registered read for the list walker
  always_ff @(posedge clk) begin
    if (cmd_take && !full) begin
      if (cmd.op == REQ_PUSH_FRONT) begin
        mem[front_dec] <= cmd.value;
      end else if (cmd.op == REQ_PUSH_BACK) begin
        mem[back_slot] <= cmd.value;
      end
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      count     <= '0;
      idx       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_take) begin
            value_out <= '0;
            last      <= 1'b1;
            unique case (cmd.op)
              REQ_PUSH_FRONT: begin
                rsp_valid <= 1'b1;
                if (full) begin
                  status <= STAT_OVERFLOW;
                end else begin
                  status <= STAT_OK;
                  front  <= front_dec;
                  count  <= count + 1'b1;
                end
              end
              REQ_PUSH_BACK: begin
                rsp_valid <= 1'b1;
                if (full) begin
                  status <= STAT_OVERFLOW;
                end else begin
                  status <= STAT_OK;
                  count  <= count + 1'b1;
                end
              end
              REQ_POP_FRONT: begin
                rsp_valid <= 1'b1;
                if (empty) begin
                  status <= STAT_UNDERFLOW;
                end else begin
                  status <= STAT_OK;
                  front  <= wrap_add(front, CNT_W'(1));
                  count  <= count - 1'b1;
                end
              end
              REQ_POP_BACK: begin
                rsp_valid <= 1'b1;
                if (empty) begin
                  status <= STAT_UNDERFLOW;
                end else begin
                  status <= STAT_OK;
                  count  <= count - 1'b1;
                end
              end
              default: begin
                // list request: walk the store unless it is empty
                if (empty) begin
                  rsp_valid <= 1'b1;
                  status    <= STAT_EMPTY_LIST;
                end else begin
                  rsp_valid <= 1'b0;
                  idx       <= '0;
                  state     <= S_READ;
                end
              end
            endcase
          end else if (out_free) begin
            rsp_valid <= 1'b0;
          end
        end
        S_READ: begin
          if (out_free) begin
            rsp_valid <= 1'b0;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            rsp_valid <= 1'b1;
            status    <= STAT_OK;
            value_out <= rdata;
            last      <= list_last;
            idx       <= idx + 1'b1;
            state     <= list_last ? S_IDLE : S_READ;
          end
        end
        default: begin
          if (out_free) begin
            rsp_valid <= 1'b0;
          end
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/double_ended_queue_core.sv
`timescale 1ns / 1ps
// bounded deque of unsigned 32-bit values on a ring buffer; depends on deq_pkg, deq_front, deq_back
// path: a push or pop request is queued in the intake FIFO, taken by the back end, and its response is registered
// throughput: one push or pop per cycle unless a list walk or rsp_stall holds it; a list
//   walk steps S_READ, S_EMIT per element: registered store read, single response register
// reset: synchronous, clears pointers, count, queue and response valid; store contents stay

module double_ended_queue_core import deq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic [2:0]            req_type,
  input  logic [DATA_WIDTH-1:0] value_in,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic [1:0]            status,
  output logic [DATA_WIDTH-1:0] value_out,
  output logic                  last
);

  logic       cmd_valid;
  cmd_t       cmd;
  logic       cmd_take;
  back_stat_t stat;

  deq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .value_in  (value_in),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  deq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .value_out (value_out),
    .last      (last),
    .stat      (stat)
  );

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stat.count <= CNT_W'(DEPTH))
    else $error("element count above depth");

  a_no_take_while_listing: assert property (@(posedge clk) disable iff (rst)
    stat.listing |-> !stat.cmd_take)
    else $error("request taken during list walk");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (stat.count == $past(stat.count) ||
                     stat.count == $past(stat.count) + 1'b1 ||
                     stat.count == $past(stat.count) - 1'b1))
    else $error("element count moved by more than one");
`endif

endmodule
